// File: src/tournament_branch_predictor_top_defines.svh
// Assertion helpers for the tournament branch predictor.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("tbp assertion failed");
// Next-cycle implication, checked outside reset.
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("tbp assertion failed");
`else
`define TBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/tbp_pkg.sv
package tbp_pkg;

	localparam int GLOBAL_ENTRIES        = 4096;
	localparam int LOCAL_HISTORY_ENTRIES = 1024;
	localparam int LOCAL_COUNTER_ENTRIES = 1024;

	localparam int GIDX_W  = $clog2(GLOBAL_ENTRIES);
	localparam int LHIDX_W = $clog2(LOCAL_HISTORY_ENTRIES);
	localparam int LCIDX_W = $clog2(LOCAL_COUNTER_ENTRIES);

	localparam int CLR_DEPTH_A = (GLOBAL_ENTRIES > LOCAL_HISTORY_ENTRIES) ?
		GLOBAL_ENTRIES : LOCAL_HISTORY_ENTRIES;
	localparam int CLR_DEPTH = (CLR_DEPTH_A > LOCAL_COUNTER_ENTRIES) ?
		CLR_DEPTH_A : LOCAL_COUNTER_ENTRIES;
	localparam int CLR_W = $clog2(CLR_DEPTH) + 1;

	localparam int GCTR_W = 2;
	localparam int LCTR_W = 3;
	localparam int CONF_W = 3;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] branch_address;
		logic        outcome;
	} in_item_t;

	typedef struct packed {
		logic              predict_taken;
		logic [CONF_W-1:0] confidence;
	} out_item_t;

	// One entry of the global-indexed table: chooser and global counter.
	typedef struct packed {
		logic [GCTR_W-1:0] chooser;
		logic [GCTR_W-1:0] gctr;
	} gentry_t;

	typedef struct packed {
		logic [GCTR_W-1:0] chooser;
		logic [GCTR_W-1:0] gctr;
		logic [LCTR_W-1:0] lctr;
	} ctr_set_t;

endpackage

// File: src/tbp_ram.sv
module tbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/tbp_train.sv
module tbp_train (
	input  tbp_pkg::ctr_set_t  cur,
	input  logic               outcome,
	output tbp_pkg::ctr_set_t  nxt,
	output tbp_pkg::out_item_t pred
);
	import tbp_pkg::*;

	logic lright;
	logic gright;

	always_comb begin
		lright = (cur.lctr[LCTR_W-1] == outcome);
		gright = (cur.gctr[GCTR_W-1] == outcome);
		nxt = cur;
		if (outcome) begin
			if (cur.lctr != '1) begin
				nxt.lctr = cur.lctr + LCTR_W'(1);
			end
			if (cur.gctr != '1) begin
				nxt.gctr = cur.gctr + GCTR_W'(1);
			end
		end else begin
			if (cur.lctr != '0) begin
				nxt.lctr = cur.lctr - LCTR_W'(1);
			end
			if (cur.gctr != '0) begin
				nxt.gctr = cur.gctr - GCTR_W'(1);
			end
		end
		// The chooser moves only when exactly one side was right.
		if (lright != gright) begin
			if (gright) begin
				if (cur.chooser != '1) begin
					nxt.chooser = cur.chooser + GCTR_W'(1);
				end
			end else if (cur.chooser != '0) begin
				nxt.chooser = cur.chooser - GCTR_W'(1);
			end
		end
		if (cur.chooser[GCTR_W-1]) begin
			pred.predict_taken = cur.gctr[GCTR_W-1];
			pred.confidence    = {cur.gctr, 1'b0};
		end else begin
			pred.predict_taken = cur.lctr[LCTR_W-1];
			pred.confidence    = cur.lctr;
		end
	end

endmodule

// File: src/tournament_branch_predictor_top.sv
// Tournament branch predictor, built around three RAMs with registered reads.
// A lookup result is registered on leaving RD2, which can wait on a full result
// register. A new item is taken only when the last is done, set by the dependent
// reads of the local history RAM and then the local counter RAM, followed by
// write-back. Reset: arst_n clears control state and the global history at
// once; a clearing pass then zeroes all tables before items are taken.
`include "tournament_branch_predictor_top_defines.svh"

module tournament_branch_predictor_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tbp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tbp_pkg::out_item_t out_data
);
	import tbp_pkg::*;

	// Sequencer states. IDLE accepts an item and issues the reads that only
	// need the item and the global history. RD1 has the local history and
	// issues the local counter read. RD2 has all three entries and either
	// drives the result register or writes the trained values back.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD1  = 2'd1;
	localparam logic [1:0] ST_RD2  = 2'd2;

	logic [1:0]         state_q;
	in_item_t           item_q;
	logic [GIDX_W-1:0]  ghr_q;
	logic               clearing_q;
	logic [CLR_W-1:0]   clr_cnt_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               accept;
	logic               finish;
	logic               upd_wr;
	logic               out_load;

	gentry_t            g_rd;
	gentry_t            g_wd;
	logic [LCIDX_W-1:0] lh_rd;
	logic [LCIDX_W-1:0] lh_wd;
	logic [LCTR_W-1:0]  lc_rd;
	logic [LCTR_W-1:0]  lc_wd;
	logic               g_we;
	logic               lh_we;
	logic               lc_we;
	logic [GIDX_W-1:0]  g_waddr;
	logic [LHIDX_W-1:0] lh_waddr;
	logic [LCIDX_W-1:0] lc_waddr;

	ctr_set_t           cur;
	ctr_set_t           nxt;
	out_item_t          pred;

	// Items are taken only in IDLE and never during the clearing pass, so
	// one item owns the RAMs from its reads to its write-back and no two
	// accesses to the same entry can overlap.
	assign in_stall = clearing_q || (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// A lookup finishes only when the result register is free or being
	// drained; an update finishes unconditionally.
	assign out_load = (state_q == ST_RD2) && (item_q.opcode == OP_LOOKUP) &&
		(!out_valid_q || !out_stall);
	assign upd_wr   = (state_q == ST_RD2) && (item_q.opcode == OP_UPDATE);
	assign finish   = out_load || upd_wr;

	assign cur.chooser = g_rd.chooser;
	assign cur.gctr    = g_rd.gctr;
	assign cur.lctr    = lc_rd;

	tbp_train u_train (
		.cur     (cur),
		.outcome (item_q.outcome),
		.nxt     (nxt),
		.pred    (pred)
	);

	// Write ports: zeros during the clearing pass, trained values otherwise.
	assign g_we  = clearing_q ? (clr_cnt_q < CLR_W'(GLOBAL_ENTRIES)) : upd_wr;
	assign lh_we = clearing_q ? (clr_cnt_q < CLR_W'(LOCAL_HISTORY_ENTRIES)) : upd_wr;
	assign lc_we = clearing_q ? (clr_cnt_q < CLR_W'(LOCAL_COUNTER_ENTRIES)) : upd_wr;

	assign g_waddr  = clearing_q ? clr_cnt_q[GIDX_W-1:0] : ghr_q;
	assign lh_waddr = clearing_q ? clr_cnt_q[LHIDX_W-1:0] :
		item_q.branch_address[2 +: LHIDX_W];
	assign lc_waddr = clearing_q ? clr_cnt_q[LCIDX_W-1:0] : lh_rd;

	assign g_wd.chooser = clearing_q ? '0 : nxt.chooser;
	assign g_wd.gctr    = clearing_q ? '0 : nxt.gctr;
	// The stored local history keeps only the bits that index the counters.
	assign lh_wd = clearing_q ? '0 : {lh_rd[LCIDX_W-2:0], item_q.outcome};
	assign lc_wd = clearing_q ? '0 : nxt.lctr;

	tbp_ram #(
		.WIDTH ($bits(gentry_t)),
		.DEPTH (GLOBAL_ENTRIES)
	) u_g_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wd),
		.re    (accept),
		.raddr (ghr_q),
		.rdata (g_rd)
	);

	tbp_ram #(
		.WIDTH (LCIDX_W),
		.DEPTH (LOCAL_HISTORY_ENTRIES)
	) u_lh_ram (
		.clk   (clk),
		.we    (lh_we),
		.waddr (lh_waddr),
		.wdata (lh_wd),
		.re    (accept),
		.raddr (in_data.branch_address[2 +: LHIDX_W]),
		.rdata (lh_rd)
	);

	// Read data of all RAMs holds while RD2 waits on a full result
	// register, since reads are issued only in IDLE and RD1.
	tbp_ram #(
		.WIDTH (LCTR_W),
		.DEPTH (LOCAL_COUNTER_ENTRIES)
	) u_lc_ram (
		.clk   (clk),
		.we    (lc_we),
		.waddr (lc_waddr),
		.wdata (lc_wd),
		.re    (state_q == ST_RD1),
		.raddr (lh_rd),
		.rdata (lc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ghr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
					if (upd_wr) begin
						ghr_q <= {ghr_q[GIDX_W-2:0], item_q.outcome};
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (out_load) begin
			out_q <= pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TBP_ASSERT_NEXT(a_accept_to_rd1, clk, arst_n, accept, state_q == ST_RD1)
	`TBP_ASSERT_NEXT(a_clear_done_stays, clk, arst_n, !clearing_q, !clearing_q)
	`TBP_ASSERT_NEXT(a_update_no_result, clk, arst_n, upd_wr && !out_stall, !out_valid)
	`TBP_ASSERT_IMP(a_no_clear_mid_item, clk, arst_n, state_q != ST_IDLE, !clearing_q)

endmodule

// File: tb/tb_tournament_branch_predictor_top.sv
module tb_tournament_branch_predictor_top;
	import tbp_pkg::*;

	// Saturation bounds of the local and global counters; the chooser shares the global bound.
	localparam int LCTR_MAX = (1 << LCTR_W) - 1;
	localparam int GCTR_MAX = (1 << GCTR_W) - 1;

	// Length of the long receiver hold-off, in clock cycles.
	localparam int HOLD_CYCLES = 300;
	// Size of the random part, of its quiet opening stretch and of the pool of recurring branches in it.
	localparam int RANDOM_ITEMS = 1000;
	localparam int QUIET_ITEMS  = 300;
	localparam int BRANCH_POOL  = 12;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	tournament_branch_predictor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the predictor tables. The histories are kept 32 bits wide
	// and only their low bits are used to index, as in the block.
	logic [GCTR_W-1:0] chooser_tbl [GLOBAL_ENTRIES];
	logic [GCTR_W-1:0] gctr_tbl    [GLOBAL_ENTRIES];
	logic [31:0]       lhist_tbl   [LOCAL_HISTORY_ENTRIES];
	logic [LCTR_W-1:0] lctr_tbl    [LOCAL_COUNTER_ENTRIES];
	logic [31:0]       ghist;

	// Predictions still owed by the block, oldest first.
	out_item_t expected_predictions[$];
	int        fail_count = 0;

	// While quiet is set neither side idles nor stalls at random. It and the
	// hold-off request are written with nonblocking assignments so that every
	// process sees the same value within one time step.
	bit quiet       = 1'b1;
	bit hold_toggle = 1'b0;
	bit hold_seen   = 1'b0;
	int hold_left   = 0;

	// A counter moves one step toward its top on a taken branch and toward
	// zero otherwise, and sticks at either bound.
	function automatic logic [LCTR_W-1:0] saturate_step(logic [LCTR_W-1:0] c,
			int unsigned top, bit up);
		if (up)
			return (c < top) ? c + 1'b1 : c;
		return (c > 0) ? c - 1'b1 : c;
	endfunction

	// Apply one accepted item to the shadow tables. A lookup queues the
	// prediction the block must return; an update trains and returns nothing.
	function automatic void predict_branch(in_item_t it);
		int unsigned gi, lbi, lpi;
		bit          lpred, gpred, lright, gright;
		out_item_t   res;
		gi  = ghist % GLOBAL_ENTRIES;
		lbi = (it.branch_address >> 2) % LOCAL_HISTORY_ENTRIES;
		lpi = lhist_tbl[lbi] % LOCAL_COUNTER_ENTRIES;
		if (it.opcode == OP_LOOKUP) begin
			if (chooser_tbl[gi][GCTR_W-1]) begin
				res.predict_taken = gctr_tbl[gi][GCTR_W-1];
				res.confidence    = CONF_W'({gctr_tbl[gi], 1'b0});
			end else begin
				res.predict_taken = lctr_tbl[lpi][LCTR_W-1];
				res.confidence    = CONF_W'(lctr_tbl[lpi]);
			end
			expected_predictions.push_back(res);
		end else begin
			lpred  = lctr_tbl[lpi][LCTR_W-1];
			gpred  = gctr_tbl[gi][GCTR_W-1];
			lright = (lpred == it.outcome);
			gright = (gpred == it.outcome);
			lctr_tbl[lpi]  = saturate_step(lctr_tbl[lpi], LCTR_MAX, it.outcome);
			lhist_tbl[lbi] = {lhist_tbl[lbi][30:0], it.outcome};
			gctr_tbl[gi]   = GCTR_W'(saturate_step(LCTR_W'(gctr_tbl[gi]), GCTR_MAX,
				it.outcome));
			// The chooser only learns when exactly one side was right.
			if (lright != gright)
				chooser_tbl[gi] = GCTR_W'(saturate_step(LCTR_W'(chooser_tbl[gi]),
					GCTR_MAX, gright));
			ghist = {ghist[30:0], it.outcome};
		end
	endfunction

	// Offer one item and hold it until the block takes it. Outside quiet
	// stretches the sender may first idle at random before offering. The
	// stall seen right after the edge is the value the block had at that
	// edge, since every signal changes through nonblocking assignments.
	task automatic send_item(in_item_t it);
		while (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_branch(it);
	endtask

	// Stop offering items and wait until every owed prediction has arrived.
	// The queue is looked at on the falling edge, away from the edge where
	// results are popped.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_predictions.size() != 0);
		@(posedge clk);
	endtask

	// After reset every counter is zero: the local side is chosen and says
	// not taken with zero confidence. A lookup ignores its outcome bit, and a
	// not-taken update leaves a zero counter at zero.
	task automatic test_reset_state();
		in_item_t it;
		it = '{opcode: OP_LOOKUP, branch_address: 32'h0000_0000, outcome: 1'b0};
		send_item(it);
		it = '{opcode: OP_LOOKUP, branch_address: 32'hFFFF_FFFF, outcome: 1'b1};
		send_item(it);
		it = '{opcode: OP_UPDATE, branch_address: 32'h0000_0000, outcome: 1'b0};
		send_item(it);
	endtask

	// A run of taken updates on one branch fills both histories with ones, so
	// the same local and global counters get trained again and again until
	// they sit at their top. The lookup then reports full local confidence.
	task automatic test_counter_saturation();
		in_item_t it;
		it = '{opcode: OP_UPDATE, branch_address: 32'hFFFF_FFFC, outcome: 1'b1};
		repeat (18)
			send_item(it);
		it.opcode = OP_LOOKUP;
		send_item(it);
	endtask

	// Branches with an empty local history all use local counter zero, which
	// is still low, while the global counter for the all-taken history is at
	// its top. Taken updates on them leave only the global side right, so the
	// chooser climbs until the global side wins the next lookup. A not-taken
	// update afterwards makes both sides wrong and must leave it alone.
	task automatic test_chooser_training();
		in_item_t it;
		for (int i = 1; i <= 3; i++) begin
			it = '{opcode: OP_UPDATE, branch_address: 32'(i * 4), outcome: 1'b1};
			send_item(it);
		end
		it = '{opcode: OP_LOOKUP, branch_address: 32'h0000_0004, outcome: 1'b0};
		send_item(it);
		it = '{opcode: OP_UPDATE, branch_address: 32'h0000_0010, outcome: 1'b0};
		send_item(it);
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering lookups back to back, so the block fills and stalls its input.
	task automatic test_output_holdoff();
		in_item_t it;
		quiet       <= 1'b1;
		hold_toggle <= ~hold_toggle;
		repeat (120) begin
			it.opcode         = OP_LOOKUP;
			it.branch_address = $urandom;
			it.outcome        = 1'($urandom_range(1));
			send_item(it);
		end
		drain_results();
	endtask

	// Random items with idling on both sides, broken by one pause in which
	// the sender waits until the block has returned everything it owes.
	task automatic test_drained_pause();
		in_item_t it;
		quiet <= 1'b0;
		for (int i = 0; i < 60; i++) begin
			if (i == 30)
				drain_results();
			it.opcode         = 1'($urandom_range(1));
			it.branch_address = $urandom;
			it.outcome        = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	// Most of the stream is a small set of recurring branches with simple
	// behavior (always, never, alternating, loop-like, random), each seen as
	// a lookup followed by its update, so the histories repeat and the
	// chooser, global and local counters all get trained in both directions.
	// The rest is updates without a lookup and fully random noise. The first
	// stretch runs with no idling on either side.
	task automatic test_random_branches();
		logic [31:0] pool_addr [BRANCH_POOL];
		int unsigned trips     [BRANCH_POOL];
		in_item_t    it;
		int unsigned roll, b;
		bit          taken;
		int          n;
		foreach (pool_addr[i]) begin
			pool_addr[i] = $urandom;
			trips[i]     = 0;
		end
		quiet <= 1'b1;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n >= QUIET_ITEMS)
				quiet <= 1'b0;
			roll = $urandom_range(99);
			b    = $urandom_range(BRANCH_POOL - 1);
			// Now and then a branch leaves the pool and a new one takes its place.
			if ($urandom_range(99) < 2)
				pool_addr[b] = $urandom;
			if (roll < 12) begin
				it.opcode         = 1'($urandom_range(1));
				it.branch_address = $urandom;
				it.outcome        = 1'($urandom_range(1));
				send_item(it);
				n++;
			end else begin
				case (b % 5)
					0:       taken = 1'b1;
					1:       taken = 1'b0;
					2:       taken = trips[b][0];
					3:       taken = (trips[b] % (3 + b % 4)) != 0;
					default: taken = 1'($urandom_range(1));
				endcase
				trips[b]++;
				if ($urandom_range(99) < 5)
					taken = !taken;
				if (roll >= 20) begin
					it.opcode         = OP_LOOKUP;
					it.branch_address = pool_addr[b];
					it.outcome        = 1'($urandom_range(1));
					send_item(it);
					n++;
				end
				it.opcode         = OP_UPDATE;
				it.branch_address = pool_addr[b];
				it.outcome        = taken;
				send_item(it);
				n++;
			end
		end
	endtask

	// Receiver side. A hold-off request makes it stall until a countdown from
	// HOLD_CYCLES runs out; otherwise it stalls at random outside quiet stretches.
	always @(posedge clk) begin
		if (hold_seen != hold_toggle) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 17);
		end
	end

	// Every result taken at an edge is checked against the oldest owed
	// prediction. The values read here are those the block held at the edge.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_predictions.size() == 0) begin
				$error("result with no lookup pending: predict_taken=%0d confidence=%0d",
					out_data.predict_taken, out_data.confidence);
				fail_count++;
			end else begin
				want = expected_predictions.pop_front();
				if (out_data.predict_taken !== want.predict_taken) begin
					$error("predict_taken: expected %0d, got %0d",
						want.predict_taken, out_data.predict_taken);
					fail_count++;
				end
				if (out_data.confidence !== want.confidence) begin
					$error("confidence: expected %0d, got %0d",
						want.confidence, out_data.confidence);
					fail_count++;
				end
			end
		end
	end

	// The run is bounded well beyond the slowest correct run: the clearing
	// pass after reset, every item at the block's rate plus sender gaps and
	// receiver stalls, and the long hold-off.
	initial begin
		#3_000_000;
		$display("** tournament_branch_predictor_top: FAILED **");
		$finish;
	end

	// After reset the block clears its tables on its own and keeps its input
	// stalled until done, which the first item simply waits out.
	initial begin
		foreach (chooser_tbl[i]) begin
			chooser_tbl[i] = '0;
			gctr_tbl[i]    = '0;
		end
		foreach (lhist_tbl[i])
			lhist_tbl[i] = '0;
		foreach (lctr_tbl[i])
			lctr_tbl[i] = '0;
		ghist = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_counter_saturation();
		test_chooser_training();
		test_output_holdoff();
		test_drained_pause();
		test_random_branches();
		drain_results();
		// Waiting on after the drain catches any result the block sends without a lookup.
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** tournament_branch_predictor_top: PASSED **");
		else
			$display("** tournament_branch_predictor_top: FAILED **");
		$finish;
	end

endmodule

// File: tournament_branch_predictor_top.f
+incdir+src
src/tbp_pkg.sv
src/tbp_ram.sv
src/tbp_train.sv
src/tournament_branch_predictor_top.sv
tb/tb_tournament_branch_predictor_top.sv
